>>> rtl/tpag_pkg.sv
// tpag_pkg: widths, reset values, register indexes and shared types of the
// tensor permute address generator. Depends on nothing.
package tpag_pkg;

  localparam int DIM_SLOTS   = 8;
  localparam int PERM_W      = 3;
  localparam int EXT_FIELD_W = 16;
  localparam int VALUE_W     = 64;
  localparam int DEST_W      = 32;
  localparam int DIM_COUNT_W = 4;
  localparam int PERM_REG_W  = DIM_SLOTS * PERM_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_DIMS_DEFAULT     = 8;
  localparam int EXTENT_WIDTH_DEFAULT = 16;
  localparam int ADDR_WIDTH_DEFAULT   = 32;

  localparam logic [DIM_COUNT_W-1:0] DIM_COUNT_RESET   = 4'd1;
  localparam logic [PERM_REG_W-1:0]  PERMUTATION_RESET = 24'hFAC688;
  localparam logic [CFG_DATA_W-1:0]  EXTENTS_RESET     = 64'h0001_0001_0001_0001;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIM_COUNT    = 2'd0,
    CFG_PERMUTATION  = 2'd1,
    CFG_EXTENTS_LOW  = 2'd2,
    CFG_EXTENTS_HIGH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic step;
    logic load;
    logic active;
    logic tail;
    logic inner;
  } cell_ctrl_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               err;
  } side_t;

endpackage

>>> rtl/tpag_ifs.sv
// tpag_in_if and tpag_out_if: valid/ready channels of the address generator.
// Depends on tpag_pkg.
interface tpag_in_if;
  import tpag_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface tpag_out_if;
  import tpag_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] moved_value;
  logic [DEST_W-1:0]  dest_address;
  logic               last_element;
  logic               setup_error;

  modport source (output valid, output moved_value, output dest_address,
                  output last_element, output setup_error, input ready);
  modport sink (input valid, input moved_value, input dest_address,
                input last_element, input setup_error, output ready);
endinterface

>>> rtl/tensor_permute_address_gen_unit.sv
// tensor_permute_address_gen_unit: top level of the tensor permute address
// generator. Depends on tpag_pkg, tpag_ifs, tpag_cell and tpag_sum.
//
// Takes one element beat per cycle in row-major input order while the output
// does not stall and the stride chain has settled, and returns each element
// with its flat address in the permuted output tensor, one result per beat.
// A row of eight cells holds the coordinate counters, whose carries ripple
// from the fastest dimension toward slot zero, and one lane multiplier each
// for the address terms, summed in a registered tree. The output strides are
// kept in a chain of shadow stages, one multiplier per cell, that settles from
// the current configuration; after reset and after every configuration write
// the input is held off while that chain settles. A job takes its strides
// from the chain on the beat at which all coordinates are zero. A setup error
// gives a result with address zero and changes no state.
module tensor_permute_address_gen_unit #(
  parameter int MAX_DIMS     = tpag_pkg::MAX_DIMS_DEFAULT,
  parameter int EXTENT_WIDTH = tpag_pkg::EXTENT_WIDTH_DEFAULT,
  parameter int ADDR_WIDTH   = tpag_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tpag_in_if.sink                          in_ch,
  tpag_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tpag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tpag_pkg::*;

  localparam int CNT_W = $clog2(DIM_SLOTS + 1);

  logic [DIM_COUNT_W-1:0]  dim_count_r;
  logic [PERM_REG_W-1:0]   perm_r;
  logic [CFG_DATA_W-1:0]   ext_lo_r, ext_hi_r;
  logic [CNT_W-1:0]        refresh_cnt_r;

  logic [2*CFG_DATA_W-1:0] ext_all;
  logic [DIM_COUNT_W-1:0]  n_dims;
  logic [EXTENT_WIDTH-1:0] extent [DIM_SLOTS];
  logic [PERM_W-1:0]       perm [DIM_SLOTS];
  logic                    cfg_err;
  logic                    accept, step, load, step_idle, last, pipe_ok;

  cell_ctrl_t              cell_ctrl [DIM_SLOTS];
  logic                    carry [DIM_SLOTS+1];
  logic [ADDR_WIDTH-1:0]   shadow [DIM_SLOTS+1];
  logic [EXTENT_WIDTH-1:0] coord [DIM_SLOTS];
  logic [EXTENT_WIDTH-1:0] lane_coord [DIM_SLOTS];
  logic [EXTENT_WIDTH-1:0] stride_factor [DIM_SLOTS];
  logic [ADDR_WIDTH-1:0]   lane_prod [DIM_SLOTS];
  side_t                   side;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_COUNT_RESET;
      perm_r      <= PERMUTATION_RESET;
      ext_lo_r    <= EXTENTS_RESET;
      ext_hi_r    <= EXTENTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIM_COUNT:    dim_count_r <= cfg_wdata[DIM_COUNT_W-1:0];
        CFG_PERMUTATION:  perm_r      <= cfg_wdata[PERM_REG_W-1:0];
        CFG_EXTENTS_LOW:  ext_lo_r    <= cfg_wdata;
        CFG_EXTENTS_HIGH: ext_hi_r    <= cfg_wdata;
      endcase
    end
  end

  // hold off input while the stride chain settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_cnt_r <= CNT_W'(DIM_SLOTS);
    end else if (cfg_we) begin
      refresh_cnt_r <= CNT_W'(DIM_SLOTS);
    end else if (refresh_cnt_r != '0) begin
      refresh_cnt_r <= refresh_cnt_r - 1'b1;
    end
  end

  assign ext_all = {ext_hi_r, ext_lo_r};
  assign n_dims  = (dim_count_r > DIM_COUNT_W'(MAX_DIMS)) ? DIM_COUNT_W'(MAX_DIMS)
                                                          : dim_count_r;

  always_comb begin
    for (int d = 0; d < DIM_SLOTS; d++) begin
      extent[d] = ext_all[d*EXT_FIELD_W +: EXTENT_WIDTH];
      perm[d]   = perm_r[d*PERM_W +: PERM_W];
    end
  end

  always_comb begin
    cfg_err = (n_dims == '0);
    for (int d = 0; d < DIM_SLOTS; d++) begin
      if (DIM_COUNT_W'(d) < n_dims) begin
        if (DIM_COUNT_W'(perm[d]) >= n_dims) cfg_err = 1'b1;
        if (extent[d] == '0) cfg_err = 1'b1;
      end
    end
  end

  always_comb begin
    step_idle = 1'b1;
    for (int d = 0; d < DIM_SLOTS; d++) begin
      if (coord[d] != '0) step_idle = 1'b0;
    end
  end

  assign in_ch.ready = pipe_ok && (refresh_cnt_r == '0);
  assign accept      = in_ch.valid && in_ch.ready;
  assign step        = accept && !cfg_err;
  assign load        = step && step_idle;
  assign last        = carry[0] && !cfg_err;

  assign carry[DIM_SLOTS]  = 1'b1;
  assign shadow[DIM_SLOTS] = '0;

  for (genvar g = 0; g < DIM_SLOTS; g++) begin : g_cell
    assign cell_ctrl[g] = '{
      step:   step,
      load:   load,
      active: DIM_COUNT_W'(g) < n_dims,
      tail:   DIM_COUNT_W'(g + 1) == n_dims,
      inner:  DIM_COUNT_W'(g + 1) < n_dims
    };
    assign lane_coord[g] = coord[perm[g]];

    if (g < DIM_SLOTS - 1) begin : g_factor
      assign stride_factor[g] = extent[perm[g+1]];
    end else begin : g_edge
      assign stride_factor[g] = '0;
    end

    tpag_cell #(
      .EXTENT_WIDTH (EXTENT_WIDTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (cell_ctrl[g]),
      .extent        (extent[g]),
      .carry_in      (carry[g+1]),
      .carry_out     (carry[g]),
      .coord         (coord[g]),
      .stride_in     (shadow[g+1]),
      .stride_factor (stride_factor[g]),
      .stride_out    (shadow[g]),
      .lane_coord    (lane_coord[g]),
      .lane_on       (!cfg_err && cell_ctrl[g].active),
      .lane_prod     (lane_prod[g])
    );
  end

  assign side = '{value: in_ch.element_value, last: last, err: cfg_err};

  tpag_sum #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (accept),
    .take_ok   (pipe_ok),
    .lane_prod (lane_prod),
    .side      (side),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("beat accepted while stride chain settles");

  a_wrap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_err && last) |=> step_idle)
    else $error("coordinates not cleared after last element");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.setup_error) |->
      (!out_ch.last_element && out_ch.dest_address == '0))
    else $error("setup error beat carries address or last flag");
`endif

endmodule

>>> rtl/tpag_cell.sv
// tpag_cell: one dimension slot: coordinate counter with carry, shadow stride
// stage of the stride chain, job stride and lane product. Depends on tpag_pkg.
module tpag_cell #(
  parameter int EXTENT_WIDTH = tpag_pkg::EXTENT_WIDTH_DEFAULT,
  parameter int ADDR_WIDTH   = tpag_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpag_pkg::cell_ctrl_t     ctrl,
  input  logic [EXTENT_WIDTH-1:0]  extent,
  input  logic                     carry_in,
  output logic                     carry_out,
  output logic [EXTENT_WIDTH-1:0]  coord,
  input  logic [ADDR_WIDTH-1:0]    stride_in,
  input  logic [EXTENT_WIDTH-1:0]  stride_factor,
  output logic [ADDR_WIDTH-1:0]    stride_out,
  input  logic [EXTENT_WIDTH-1:0]  lane_coord,
  input  logic                     lane_on,
  output logic [ADDR_WIDTH-1:0]    lane_prod
);
  import tpag_pkg::*;

  logic [EXTENT_WIDTH-1:0]            coord_r, coord_nxt;
  logic [EXTENT_WIDTH:0]              coord_inc;
  logic                               at_top;
  logic [ADDR_WIDTH-1:0]              shadow_r, shadow_nxt;
  logic [ADDR_WIDTH-1:0]              stride_r, stride_nxt;
  logic [ADDR_WIDTH+EXTENT_WIDTH-1:0] shadow_prod, lane_full;

  assign coord     = ctrl.active ? coord_r : '0;
  assign coord_inc = {1'b0, coord} + 1'b1;
  assign at_top    = coord_inc >= {1'b0, extent};
  assign carry_out = ctrl.active ? (carry_in & at_top) : carry_in;

  always_comb begin
    coord_nxt = coord_r;
    if (ctrl.step) begin
      if (!ctrl.active) begin
        coord_nxt = '0;
      end else if (carry_in) begin
        coord_nxt = at_top ? '0 : coord_inc[EXTENT_WIDTH-1:0];
      end
    end
  end

  // shadow stride settles from the neighbor toward slot zero
  assign shadow_prod = stride_in * stride_factor;

  always_comb begin
    priority if (ctrl.tail) begin
      shadow_nxt = ADDR_WIDTH'(1);
    end else if (ctrl.inner) begin
      shadow_nxt = shadow_prod[ADDR_WIDTH-1:0];
    end else begin
      shadow_nxt = '0;
    end
  end

  assign stride_nxt = ctrl.load ? shadow_r : stride_r;
  assign stride_out = shadow_r;

  assign lane_full = lane_coord * stride_r;
  assign lane_prod = lane_on ? lane_full[ADDR_WIDTH-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else begin
      coord_r <= coord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r <= '0;
      stride_r <= '0;
    end else begin
      shadow_r <= shadow_nxt;
      stride_r <= stride_nxt;
    end
  end

endmodule

>>> rtl/tpag_sum.sv
// tpag_sum: lane product register, two adder tree levels and an output register
// that adds the last pair, with per-stage valids. Depends on tpag_pkg and tpag_out_if.
module tpag_sum #(
  parameter int ADDR_WIDTH = tpag_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_beat,
  output logic                  take_ok,
  input  logic [ADDR_WIDTH-1:0] lane_prod [tpag_pkg::DIM_SLOTS],
  input  tpag_pkg::side_t       side,
  tpag_out_if.source            out_ch
);
  import tpag_pkg::*;

  localparam int HALF    = DIM_SLOTS / 2;
  localparam int QUARTER = DIM_SLOTS / 4;

  logic                  v1_r, v2_r, v3_r, vo_r;
  logic                  go1, go2, go3, go_o;
  logic [ADDR_WIDTH-1:0] p1_r [DIM_SLOTS];
  logic [ADDR_WIDTH-1:0] sum2_r [HALF];
  logic [ADDR_WIDTH-1:0] sum3_r [QUARTER];
  logic [ADDR_WIDTH-1:0] addr_r;
  side_t                 s1_r, s2_r, s3_r, so_r;
  logic [ADDR_WIDTH+DEST_W-1:0] addr_wide;

  assign go_o    = !vo_r || out_ch.ready;
  assign go3     = !v3_r || go_o;
  assign go2     = !v2_r || go3;
  assign go1     = !v1_r || go2;
  assign take_ok = go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (go1) v1_r <= in_beat;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go_o) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      p1_r <= lane_prod;
      s1_r <= side;
    end
    if (go2) begin
      for (int i = 0; i < HALF; i++) begin
        sum2_r[i] <= p1_r[2*i] + p1_r[2*i+1];
      end
      s2_r <= s1_r;
    end
    if (go3) begin
      for (int j = 0; j < QUARTER; j++) begin
        sum3_r[j] <= sum2_r[2*j] + sum2_r[2*j+1];
      end
      s3_r <= s2_r;
    end
    if (go_o) begin
      addr_r <= sum3_r[0] + sum3_r[1];
      so_r   <= s3_r;
    end
  end

  assign addr_wide = {{DEST_W{1'b0}}, addr_r};

  assign out_ch.valid        = vo_r;
  assign out_ch.moved_value  = so_r.value;
  assign out_ch.dest_address = addr_wide[DEST_W-1:0];
  assign out_ch.last_element = so_r.last;
  assign out_ch.setup_error  = so_r.err;

endmodule
